[rtl/assert_macros.svh]
// Assertion helper macros shared by the RTL.
// Needs signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GMEL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gmel: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define GMEL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gmel: next-cycle check failed");

`endif

[rtl/gmel_pkg.sv]
// Package for the group mutual exclusion lock: field widths, codes, status struct.
// No dependencies.
package gmel_pkg;

   // payload widths of the two channels
   localparam int KIND_W   = 1;
   localparam int GROUP_W  = 8;
   localparam int STATUS_W = 3;
   localparam int RGRP_W   = 3;
   localparam int RCNT_W   = 8;
   localparam int OGRP_W   = 3;

   // request kinds
   localparam logic KIND_ENTER = 1'b0;
   localparam logic KIND_EXIT  = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ENTERED      = 3'd0,
      ST_QUEUED_FIRST = 3'd1,
      ST_WAIT_JOINED  = 3'd2,
      ST_LEFT_HELD    = 3'd3,
      ST_HANDED_OVER  = 3'd4,
      ST_FREED        = 3'd5,
      ST_REJECTED     = 3'd6
   } gmel_status_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic busy;        // an item is being executed
      logic owner_held;  // lock held by some group
      logic waiting;     // wait FIFO not empty
   } gmel_stat_type;

endpackage

[rtl/gmel_intf.sv]
// Channel interfaces for request and response transfers.
// Depends on gmel_pkg for payload widths.
interface gmel_req_if import gmel_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [GROUP_W-1:0] group;

   modport source (output valid, output kind, output group, input ready);
   modport sink   (input valid, input kind, input group, output ready);
endinterface

interface gmel_rsp_if import gmel_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RGRP_W-1:0]   released_group;
   logic [RCNT_W-1:0]   released_count;
   logic                owner_valid;
   logic [OGRP_W-1:0]   owner_group;

   modport source (output valid, output status, output released_group,
                   output released_count, output owner_valid, output owner_group,
                   input ready);
   modport sink   (input valid, input status, input released_group,
                   input released_count, input owner_valid, input owner_group,
                   output ready);
endinterface

[rtl/gmel_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/gmel_front.sv]
// Front end: takes request transfers, range-checks the group and forms a queue entry.
// Depends on gmel_pkg and gmel_req_if.
module gmel_front import gmel_pkg::*; #(
   parameter int NUM_GROUPS = 8
) (
   gmel_req_if.sink                        req,
   output logic                            push_valid,
   input  logic                            push_ready,
   output logic [$clog2(NUM_GROUPS)+1:0]   push_data
);

   localparam int GW = $clog2(NUM_GROUPS);

   logic          bad;
   logic [GW-1:0] grp;

   // out-of-range groups are flagged here and rejected by the back end
   assign bad = (req.group >= GROUP_W'(NUM_GROUPS));
   assign grp = req.group[GW-1:0];

   // entry layout: {bad, kind, group}
   assign push_data  = {bad, req.kind, grp};
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

[rtl/gmel_fifo.sv]
// Short FIFO between front and back end, register storage.
// No dependencies.
module gmel_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/gmel_back.sv]
// Back end: executes queued requests against the lock state and drives responses.
// Depends on gmel_pkg, gmel_rsp_if and gmel_ram.
module gmel_back import gmel_pkg::*; #(
   parameter int NUM_GROUPS  = 8,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  logic [$clog2(NUM_GROUPS)+1:0]   pop_data,
   gmel_rsp_if.source                      rsp,
   output gmel_stat_type                   stat
);

   localparam int GW = $clog2(NUM_GROUPS);
   localparam int FW = $clog2(NUM_GROUPS + 1);
   localparam logic [GW:0]          NG_SUM    = (GW + 1)'(NUM_GROUPS);
   localparam logic [GW-1:0]        LAST_IDX  = GW'(NUM_GROUPS - 1);
   localparam logic [FW-1:0]        FILL_FULL = FW'(NUM_GROUPS);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HAND} state_type;

   // saturate a member count to the response field
   function automatic logic [RCNT_W-1:0] sat_cnt(input logic [COUNT_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd255) ? '1 : w[RCNT_W-1:0];
   endfunction

   // group index to the response field
   function automatic logic [RGRP_W-1:0] grp_out(input logic [GW-1:0] g);
      logic [7:0] w;
      w = 8'(g);
      return w[RGRP_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic                  kind_ff, kind_in;
   logic                  bad_ff, bad_in;
   logic [GW-1:0]         grp_ff, grp_in;
   logic                  owner_vld_ff, owner_vld_in;
   logic [GW-1:0]         owner_id_ff, owner_id_in;
   logic [GW-1:0]         head_ff, head_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [NUM_GROUPS-1:0] cnt_valid_ff, cnt_valid_in;
   logic                  cnt_rvld_ff, cnt_rvld_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   gmel_status_type       rsp_status_ff, rsp_status_in;
   logic [RGRP_W-1:0]     rsp_rgrp_ff, rsp_rgrp_in;
   logic [RCNT_W-1:0]     rsp_rcnt_ff, rsp_rcnt_in;
   logic                  rsp_ovld_ff, rsp_ovld_in;
   logic [OGRP_W-1:0]     rsp_ogrp_ff, rsp_ogrp_in;

   logic                   pop_bad, pop_kind;
   logic [GW-1:0]          pop_grp;
   logic [COUNT_WIDTH-1:0] cnt_rdata, cnt, cnt_wdata;
   logic [GW-1:0]          cnt_raddr;
   logic                   cnt_we;
   logic [GW-1:0]          wq_rdata, tail;
   logic                   wq_we;
   logic [GW:0]            tail_sum;
   logic                   slot_free, load;
   gmel_status_type        res_status;
   logic [GW-1:0]          res_rgrp;
   logic [COUNT_WIDTH-1:0] res_rcnt;

   assign {pop_bad, pop_kind, pop_grp} = pop_data;
   assign slot_free = !rsp_vld_ff || rsp.ready;
   assign cnt       = cnt_rvld_ff ? cnt_rdata : '0;

   // tail of the wait FIFO, wrapped at the group count
   assign tail_sum = {1'b0, head_ff} + (GW + 1)'(fill_ff);
   assign tail     = (tail_sum >= NG_SUM) ? GW'(tail_sum - NG_SUM) : GW'(tail_sum);

   // member counts, valid bits stand for the all-zero reset
   gmel_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_GROUPS)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (grp_ff),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   // wait FIFO of groups, read at the head
   gmel_ram #(.WIDTH(GW), .DEPTH(NUM_GROUPS)) u_wq_ram (
      .clock (clock),
      .we    (wq_we),
      .waddr (tail),
      .wdata (grp_ff),
      .raddr (head_ff),
      .rdata (wq_rdata)
   );

   // execution sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      bad_in       = bad_ff;
      grp_in       = grp_ff;
      owner_vld_in = owner_vld_ff;
      owner_id_in  = owner_id_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cnt_valid_in = cnt_valid_ff;
      pop_ready    = 1'b0;
      cnt_raddr    = grp_ff;
      cnt_we       = 1'b0;
      cnt_wdata    = cnt + 1'b1;
      wq_we        = 1'b0;
      load         = 1'b0;
      res_status   = ST_REJECTED;
      res_rgrp     = '0;
      res_rcnt     = '0;

      case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            cnt_raddr = pop_grp;
            if (pop_valid) begin
               kind_in  = pop_kind;
               bad_in   = pop_bad;
               grp_in   = pop_grp;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (!bad_ff && kind_ff == KIND_EXIT && cnt == COUNT_WIDTH'(1) &&
                owner_vld_ff && owner_id_ff == grp_ff && fill_ff != '0) begin
               // last member leaves, lock passes to the head of the FIFO
               cnt_we       = 1'b1;
               cnt_wdata    = '0;
               head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
               fill_in      = fill_ff - 1'b1;
               owner_id_in  = wq_rdata;
               owner_vld_in = 1'b1;
               cnt_raddr    = wq_rdata;
               state_in     = S_HAND;
            end else if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               if (bad_ff) begin
                  res_status = ST_REJECTED;
               end else if (kind_ff == KIND_ENTER) begin
                  if (cnt == CNT_MAX) begin
                     res_status = ST_REJECTED;
                  end else if (cnt == '0) begin
                     if (!owner_vld_ff) begin
                        cnt_we       = 1'b1;
                        owner_vld_in = 1'b1;
                        owner_id_in  = grp_ff;
                        res_status   = ST_ENTERED;
                        res_rgrp     = grp_ff;
                        res_rcnt     = COUNT_WIDTH'(1);
                     end else if (fill_ff >= FILL_FULL) begin
                        res_status = ST_REJECTED;
                     end else begin
                        cnt_we     = 1'b1;
                        wq_we      = 1'b1;
                        fill_in    = fill_ff + 1'b1;
                        res_status = ST_QUEUED_FIRST;
                     end
                  end else begin
                     cnt_we = 1'b1;
                     if (owner_vld_ff && owner_id_ff == grp_ff) begin
                        res_status = ST_ENTERED;
                        res_rgrp   = grp_ff;
                        res_rcnt   = COUNT_WIDTH'(1);
                     end else begin
                        res_status = ST_WAIT_JOINED;
                     end
                  end
               end else begin
                  if (cnt == '0 || !owner_vld_ff || owner_id_ff != grp_ff) begin
                     res_status = ST_REJECTED;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt - 1'b1;
                     if (cnt != COUNT_WIDTH'(1)) begin
                        res_status = ST_LEFT_HELD;
                     end else begin
                        owner_vld_in = 1'b0;
                        owner_id_in  = '0;
                        res_status   = ST_FREED;
                     end
                  end
               end
            end
         end

         S_HAND: begin
            // count of the new owner read at its id
            cnt_raddr = owner_id_ff;
            if (slot_free) begin
               load       = 1'b1;
               res_status = ST_HANDED_OVER;
               res_rgrp   = owner_id_ff;
               res_rcnt   = cnt;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cnt_we) begin
         cnt_valid_in[grp_ff] = 1'b1;
      end
      cnt_rvld_in = cnt_valid_ff[cnt_raddr];
   end

   // response register
   always_comb begin
      rsp_vld_in    = rsp_vld_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rgrp_in   = rsp_rgrp_ff;
      rsp_rcnt_in   = rsp_rcnt_ff;
      rsp_ovld_in   = rsp_ovld_ff;
      rsp_ogrp_in   = rsp_ogrp_ff;
      if (load) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = res_status;
         rsp_rcnt_in   = sat_cnt(res_rcnt);
         rsp_rgrp_in   = (res_rcnt != '0) ? grp_out(res_rgrp) : '0;
         rsp_ovld_in   = owner_vld_in;
         rsp_ogrp_in   = owner_vld_in ? grp_out(owner_id_in) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         owner_vld_ff <= 1'b0;
         owner_id_ff  <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         cnt_valid_ff <= '0;
         cnt_rvld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         owner_vld_ff <= owner_vld_in;
         owner_id_ff  <= owner_id_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cnt_valid_ff <= cnt_valid_in;
         cnt_rvld_ff  <= cnt_rvld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      kind_ff       <= kind_in;
      bad_ff        <= bad_in;
      grp_ff        <= grp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rgrp_ff   <= rsp_rgrp_in;
      rsp_rcnt_ff   <= rsp_rcnt_in;
      rsp_ovld_ff   <= rsp_ovld_in;
      rsp_ogrp_ff   <= rsp_ogrp_in;
   end

   assign rsp.valid          = rsp_vld_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.released_group = rsp_rgrp_ff;
   assign rsp.released_count = rsp_rcnt_ff;
   assign rsp.owner_valid    = rsp_ovld_ff;
   assign rsp.owner_group    = rsp_ogrp_ff;

   assign stat.busy       = (state_ff != S_IDLE);
   assign stat.owner_held = owner_vld_ff;
   assign stat.waiting    = (fill_ff != '0);

endmodule

[rtl/group_mutual_exclusion_lock.sv]
// Group mutual exclusion lock: front end, 2-entry queue, back-end sequencer.
// The back end takes one request at a time, stalls while its response is not taken,
// and adds a step on a hand-over; the registered read of the member-count RAM comes
// ahead of each execution step.
// Reset (synchronous): lock free, counts zero, wait FIFO empty; no clearing pass.
// Depends on gmel_pkg, gmel_intf, gmel_front, gmel_fifo, gmel_back, assert_macros.svh.
`include "assert_macros.svh"

module group_mutual_exclusion_lock import gmel_pkg::*; #(
   parameter int NUM_GROUPS  = 8,
   parameter int COUNT_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   gmel_req_if.sink   req_bus,
   gmel_rsp_if.source rsp_bus
);

   localparam int GW       = $clog2(NUM_GROUPS);
   localparam int ENTRY_W  = GW + 2;
   localparam int Q_DEPTH  = 2;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   gmel_stat_type      stat;

   gmel_front #(.NUM_GROUPS(NUM_GROUPS)) u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   gmel_fifo #(.WIDTH(ENTRY_W), .DEPTH(Q_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gmel_back #(.NUM_GROUPS(NUM_GROUPS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_bus),
      .stat      (stat)
   );

   // a waiting group implies the lock is held by another
   `GMEL_ASSERT_NOW(a_wait_needs_owner, stat.waiting, stat.owner_held)
   // an accepted request is queued or in execution on the next cycle
   `GMEL_ASSERT_NEXT(a_req_not_lost, req_bus.valid && req_bus.ready, pop_valid || stat.busy)
   // a hand-over names the new owner and releases its members
   `GMEL_ASSERT_NOW(a_handover_fields,
      rsp_bus.valid && rsp_bus.status == ST_HANDED_OVER,
      rsp_bus.owner_valid && rsp_bus.owner_group == rsp_bus.released_group &&
      rsp_bus.released_count != '0)
   // a rejected request releases nobody
   `GMEL_ASSERT_NOW(a_reject_quiet, rsp_bus.valid && rsp_bus.status == ST_REJECTED,
      rsp_bus.released_count == '0 && rsp_bus.released_group == '0)

endmodule
